// ===== hw/rtl/pcp_pkg.sv =====
// Shared types, constants and a helper function for the position command parser.
// Used by the front classifier, the item queue and the back-end parser.
`default_nettype none
package pcp_pkg;

  localparam int MAX_LENGTH = 10;
  localparam int MIN_LENGTH = 4;
  localparam int MAX_DIGITS = 4;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam int CHAR_W  = 8;
  localparam int COORD_W = 14;
  localparam int LEN_W   = 4;
  localparam int DCNT_W  = 3;
  localparam int ERR_W   = 3;

  localparam logic [LEN_W-1:0]   LEN_MAX = 4'd15;
  localparam logic [COORD_W-1:0] ACC_MAX = 14'd16383;

  localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_SHORT     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_LONG      = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NO_P      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_X     = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NO_COMMA  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_BAD_Y     = 3'd6;

  typedef struct packed {
    logic       is_p;
    logic       is_comma;
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } cls_t;

  typedef struct packed {
    logic [ERR_W-1:0]   error_code;
    logic [COORD_W-1:0] y_pos;
    logic [COORD_W-1:0] x_pos;
    logic               parse_ok;
  } res_t;

  typedef enum logic [3:0] {
    PH_P    = 4'b0001,
    PH_X    = 4'b0010,
    PH_Y    = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  function automatic logic [COORD_W-1:0] acc_step(input logic [COORD_W-1:0] acc,
                                                  input logic [3:0] d);
    logic [COORD_W+3:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{COORD_W{1'b0}}, d};
    if (v > {4'd0, ACC_MAX}) begin
      acc_step = ACC_MAX;
    end else begin
      acc_step = v[COORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pcp_front.sv =====
// Front end: takes message bytes from the input stream and classifies each one.
// Depends on pcp_pkg; feeds classified bytes into pcp_queue.
`default_nettype none
module pcp_front (
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [pcp_pkg::CHAR_W-1:0] in_tdata,  // [7:0] char_byte
  input  wire logic                       in_tlast,  // last_byte
  output logic                            wr_valid,
  input  wire logic                       wr_ready,
  output pcp_pkg::cls_t                   wr_data
);
  import pcp_pkg::*;

  assign in_tready = wr_ready;
  assign wr_valid  = in_tvalid;

  always_comb begin
    wr_data          = '0;
    wr_data.is_p     = (in_tdata == CH_P);
    wr_data.is_comma = (in_tdata == CH_COMMA);
    wr_data.is_digit = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
    wr_data.digit    = in_tdata[3:0];
    wr_data.last     = in_tlast;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pcp_queue.sv =====
// Short queue of classified bytes between the front end and the parser.
// Depends on pcp_pkg for the item type and depth.
`default_nettype none
module pcp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire pcp_pkg::cls_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output pcp_pkg::cls_t      rd_data
);
  import pcp_pkg::*;

  cls_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != QDEPTH[QPTR_W:0]);
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH[QPTR_W:0])
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule
`default_nettype wire

// ===== hw/rtl/pcp_back.sv =====
// Back end: runs the message parser over classified bytes and holds the result.
// Depends on pcp_pkg; reads from pcp_queue and drives the result stream.
`default_nettype none
module pcp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_valid,
  output logic               rd_ready,
  input  wire pcp_pkg::cls_t rd_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pcp_pkg::res_t      out_data
);
  import pcp_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [COORD_W-1:0] x_r, x_nxt;
  logic [COORD_W-1:0] y_r, y_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [ERR_W-1:0]   ferr_r, ferr_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;
  logic [ERR_W-1:0]   err;
  logic               pop;
  logic               x_full;

  assign rd_ready  = !rd_data.last || !out_valid_r || out_ready;
  assign pop       = rd_valid && rd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign x_full    = (dcnt_r >= DCNT_W'(MAX_DIGITS));

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = (len_r < LEN_MAX) ? len_r + 1'b1 : len_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    dcnt_nxt  = dcnt_r;
    ferr_nxt  = ferr_r;

    case (phase_r)
      PH_P: begin
        if (rd_data.is_p) begin
          phase_nxt = PH_X;
        end else begin
          ferr_nxt  = ERR_NO_P;
          phase_nxt = PH_DONE;
        end
      end
      PH_X: begin
        if (x_full) begin
          if (rd_data.is_comma) begin
            phase_nxt = PH_Y;
            dcnt_nxt  = '0;
          end else begin
            ferr_nxt  = ERR_NO_COMMA;
            phase_nxt = PH_DONE;
          end
        end else if (rd_data.is_digit) begin
          x_nxt    = acc_step(x_r, rd_data.digit);
          dcnt_nxt = dcnt_r + 1'b1;
        end else if (rd_data.is_comma) begin
          phase_nxt = PH_Y;
          dcnt_nxt  = '0;
        end else begin
          ferr_nxt  = ERR_BAD_X;
          phase_nxt = PH_DONE;
        end
      end
      PH_Y: begin
        if (rd_data.is_digit) begin
          y_nxt    = acc_step(y_r, rd_data.digit);
          dcnt_nxt = dcnt_r + 1'b1;
          if (dcnt_nxt >= DCNT_W'(MAX_DIGITS)) begin
            phase_nxt = PH_DONE;
          end
        end else begin
          ferr_nxt  = ERR_BAD_Y;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (len_nxt < LEN_W'(MIN_LENGTH)) begin
      err = ERR_SHORT;
    end else if (len_nxt > LEN_W'(MAX_LENGTH)) begin
      err = ERR_LONG;
    end else if (ferr_nxt != ERR_NONE) begin
      err = ferr_nxt;
    end else if (phase_nxt == PH_X) begin
      err = (dcnt_nxt >= DCNT_W'(MAX_DIGITS)) ? ERR_NO_COMMA : ERR_BAD_X;
    end else if (phase_nxt == PH_P) begin
      err = ERR_NO_P;
    end else begin
      err = ERR_NONE;
    end

    res_nxt            = res_r;
    res_nxt.parse_ok   = (err == ERR_NONE);
    res_nxt.x_pos      = (err == ERR_NONE) ? x_nxt : '0;
    res_nxt.y_pos      = (err == ERR_NONE) ? y_nxt : '0;
    res_nxt.error_code = err;

    out_valid_nxt = out_valid_r && !out_ready;
    if (pop && rd_data.last) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = PH_P;
      len_nxt       = '0;
      x_nxt         = '0;
      y_nxt         = '0;
      dcnt_nxt      = '0;
      ferr_nxt      = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_P;
      len_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      dcnt_r      <= '0;
      ferr_r      <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      dcnt_r      <= dcnt_nxt;
      ferr_r      <= ferr_nxt;
      out_valid_r <= out_valid_nxt;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && rd_data.last) begin
      res_r <= res_nxt;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && rd_data.last) |=> (phase_r == PH_P && len_r == '0 && ferr_r == ERR_NONE))
    else $error("parser state not cleared after a message");

  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.parse_ok == (res_r.error_code == ERR_NONE)))
    else $error("parse_ok disagrees with error_code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.parse_ok) |-> (res_r.x_pos == '0 && res_r.y_pos == '0))
    else $error("coordinates not cleared on error");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(pop && rd_data.last))
    else $error("result overwritten before transfer");

endmodule
`default_nettype wire

// ===== hw/rtl/position_command_parser.sv =====
// Top level of the position command parser: front classifier, queue and parser.
// Depends on pcp_pkg, pcp_front, pcp_queue and pcp_back.
`default_nettype none
// Parses text messages of the form p<x>,<y> arriving one byte per transfer, with
// in_tlast on the final byte, and gives one result transfer per message carrying
// parse_ok, x, y and an error code. A byte can be accepted every clock while the
// queue has room. A four-entry queue sits between classification and parsing, and the
// result is held in an output register, so input keeps flowing while a result waits
// to be taken until the queue fills. The last byte is stored in the queue, and its
// result is then registered in the output register.
module position_command_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [0] parse_ok, [14:1] x_pos, [28:15] y_pos,
                                       // [31:29] error_code
);
  import pcp_pkg::*;

  logic wr_valid, wr_ready;
  cls_t wr_data;
  logic rd_valid, rd_ready;
  cls_t rd_data;
  res_t res;

  pcp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .wr_valid  (wr_valid),
    .wr_ready  (wr_ready),
    .wr_data   (wr_data)
  );

  pcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data)
  );

  pcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_ready  (rd_ready),
    .rd_data   (rd_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = res;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the position command parser.
// Drives byte streams through directed and random messages and checks every result
// against an in-bench prediction; depends on pcp_pkg and position_command_parser.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  position_command_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  phase_t             exp_phase;
  logic [LEN_W-1:0]   exp_len;
  logic [COORD_W-1:0] exp_x;
  logic [COORD_W-1:0] exp_y;
  logic [DCNT_W-1:0]  exp_digits;
  logic [ERR_W-1:0]   exp_first_err;

  res_t pending_positions[$];

  bit no_stall;
  int mismatches;
  int n_bytes;
  int n_messages;
  int n_results;
  int n_parsed;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function void clear_parse_state();
    exp_phase     = PH_P;
    exp_len       = '0;
    exp_x         = '0;
    exp_y         = '0;
    exp_digits    = '0;
    exp_first_err = ERR_NONE;
  endfunction

  function automatic logic [COORD_W-1:0] decimal_push(input logic [COORD_W-1:0] acc,
                                                      input logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - int'(CH_ZERO);
    return (v > int'(ACC_MAX)) ? ACC_MAX : v[COORD_W-1:0];
  endfunction

  function void flag_error(input logic [ERR_W-1:0] code);
    exp_first_err = code;
    exp_phase     = PH_DONE;
  endfunction

  function void predict_position(input logic [7:0] c, input logic last);
    logic is_digit;
    logic [ERR_W-1:0] code;
    res_t r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (exp_len < LEN_MAX) exp_len = exp_len + 1'b1;
    case (exp_phase)
      PH_P: begin
        if (c == CH_P) exp_phase = PH_X;
        else flag_error(ERR_NO_P);
      end
      PH_X: begin
        if (exp_digits >= MAX_DIGITS) begin
          if (c == CH_COMMA) begin
            exp_phase  = PH_Y;
            exp_digits = '0;
          end else begin
            flag_error(ERR_NO_COMMA);
          end
        end else if (is_digit) begin
          exp_x      = decimal_push(exp_x, c);
          exp_digits = exp_digits + 1'b1;
        end else if (c == CH_COMMA) begin
          exp_phase  = PH_Y;
          exp_digits = '0;
        end else begin
          flag_error(ERR_BAD_X);
        end
      end
      PH_Y: begin
        if (is_digit) begin
          exp_y      = decimal_push(exp_y, c);
          exp_digits = exp_digits + 1'b1;
          if (exp_digits >= MAX_DIGITS) exp_phase = PH_DONE;
        end else begin
          flag_error(ERR_BAD_Y);
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      if (exp_len < MIN_LENGTH) code = ERR_SHORT;
      else if (exp_len > MAX_LENGTH) code = ERR_LONG;
      else if (exp_first_err != ERR_NONE) code = exp_first_err;
      else if (exp_phase == PH_X) code = (exp_digits >= MAX_DIGITS) ? ERR_NO_COMMA : ERR_BAD_X;
      else if (exp_phase == PH_P) code = ERR_NO_P;
      else code = ERR_NONE;
      r.parse_ok   = (code == ERR_NONE);
      r.x_pos      = (code == ERR_NONE) ? exp_x : '0;
      r.y_pos      = (code == ERR_NONE) ? exp_y : '0;
      r.error_code = code;
      pending_positions.push_back(r);
      n_messages++;
      clear_parse_state();
    end
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_position(c, last);
    n_bytes++;
  endtask

  task automatic send_bytes(input logic [7:0] msg[$]);
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] msg[$];
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    send_bytes(msg);
  endtask

  task automatic test_valid_positions();
    send_text("p0,0");
    send_text("p9999,9999");
    send_text("p12,34");
    send_text("p,56");
    send_text("p78,");
    send_text("p1234,5678");
  endtask

  task automatic test_length_limits();
    send_text("p");
    send_text("p1,");
    send_text("p1234,56789");
    send_text("zzzzzzzzzzzzzzzzzzzz");
  endtask

  task automatic test_content_errors();
    send_text("q12,34");
    send_text("p1a,34");
    send_text("p12345,6");
    send_text("p12,3b");
    send_text("p123");
    send_text("p1234");
    send_text("pa,b,c");
    send_text("p1,1234zz");
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic test_random_traffic(input int target_bytes);
    logic [7:0] msg[$];
    int kind;
    int n;
    int start;
    start = n_bytes;
    while (n_bytes - start < target_bytes) begin
      msg.delete();
      kind = $urandom_range(0, 99);
      no_stall = ($urandom_range(0, 3) == 0);
      if (kind < 82) begin
        msg.push_back(CH_P);
        n = (kind >= 60 && kind < 70) ? $urandom_range(5, 6) : $urandom_range(0, 4);
        repeat (n) msg.push_back(rand_digit());
        msg.push_back(CH_COMMA);
        n = $urandom_range(0, 4);
        repeat (n) msg.push_back(rand_digit());
        if (n == 4 && $urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
        end
        if (kind >= 70) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15) begin
          n = $urandom_range(1, msg.size());
          while (msg.size() > n) void'(msg.pop_back());
        end
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 16)) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 14)) begin
          case ($urandom_range(0, 3))
            0: msg.push_back(CH_P);
            1: msg.push_back(CH_COMMA);
            2: msg.push_back(rand_digit());
            default: msg.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      send_bytes(msg);
    end
    no_stall = 1'b0;
  endtask

  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata);
      if (pending_positions.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $realtime, out_tdata);
        mismatches++;
      end else begin
        want = pending_positions.pop_front();
        n_results++;
        if (got.parse_ok) n_parsed++;
        if (got.parse_ok !== want.parse_ok) begin
          $display("%0t: parse_ok expected %0d actual %0d", $realtime, want.parse_ok,
                   got.parse_ok);
          mismatches++;
        end
        if (got.x_pos !== want.x_pos) begin
          $display("%0t: x_pos expected %0d actual %0d", $realtime, want.x_pos, got.x_pos);
          mismatches++;
        end
        if (got.y_pos !== want.y_pos) begin
          $display("%0t: y_pos expected %0d actual %0d", $realtime, want.y_pos, got.y_pos);
          mismatches++;
        end
        if (got.error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $realtime, want.error_code,
                   got.error_code);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int waited;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    no_stall  = 1'b0;
    clear_parse_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_valid_positions();
    test_length_limits();
    test_content_errors();
    test_random_traffic(1800);
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_positions.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_positions.size() > 0) begin
      $display("%0t: timed out with %0d results outstanding", $realtime,
               pending_positions.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      $display("Streamed %0d messages in %0d bytes; %0d results checked, %0d valid positions.",
               n_messages, n_bytes, n_results, n_parsed);
      if (mismatches == 0) begin
        $display("== PASS ==");
      end else begin
        $display("%0d mismatches", mismatches);
        $display("== FAIL ==");
      end
      $finish;
    end
  end

endmodule
`default_nettype wire
